>>> rtl/core/imu_frame_sync_checksum_parser_unit_assert.svh
// Assertion macros shared by the parser RTL.
// Both expect clk_i to be visible at the point of use; IFSC_ASSERT also expects rst_ni.
`ifndef IMU_FRAME_SYNC_CHECKSUM_PARSER_UNIT_ASSERT_SVH
`define IMU_FRAME_SYNC_CHECKSUM_PARSER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define IFSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define IFSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/ifsc_pkg.sv
package ifsc_pkg;

  localparam int unsigned PayloadLen = 20;
  localparam int unsigned ValueCount = 10;
  localparam int unsigned IdxW       = $clog2(PayloadLen + 1);
  localparam int unsigned CountW     = 16;
  localparam int unsigned ProdW      = 28;
  localparam int unsigned OutDataW   = 264;

  localparam logic [7:0] HdrFirst  = 8'h7F;
  localparam logic [7:0] HdrSecond = 8'h80;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Full-scale factor per value: accel x3, rate x3, angle x3, temperature.
  localparam logic signed [11:0] ScaleTab [ValueCount] = '{
    12'sd20, 12'sd20, 12'sd20, 12'sd1260, 12'sd1260, 12'sd1260,
    12'sd360, 12'sd360, 12'sd360, 12'sd200
  };

  typedef struct packed {
    logic [PayloadLen-1:0][7:0] payload;
    logic [CountW-1:0]          count;
  } ifsc_frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ifsc_fifo_status_t;

endpackage

>>> rtl/core/ifsc_front.sv
module ifsc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  input  logic                 chunk_end_i,
  input  ifsc_pkg::ifsc_fifo_status_t fifo_status_i,
  output logic                 push_o,
  output ifsc_pkg::ifsc_frame_t frame_o
);
  import ifsc_pkg::*;

  localparam logic [1:0] PhHunt  = 2'd0;
  localparam logic [1:0] PhHdr1  = 2'd1;
  localparam logic [1:0] PhData  = 2'd2;
  localparam logic [1:0] PhCheck = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [7:0]        sum_q, sum_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [7:0]        store_q [PayloadLen];
  logic              accept;
  logic              good;

  assign in_ready_o = !fifo_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    good    = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PhHunt: begin
          if (rx_byte_i == HdrFirst) phase_d = PhHdr1;
        end
        PhHdr1: begin
          if (rx_byte_i == HdrSecond) begin
            phase_d = PhData;
            idx_d   = '0;
            sum_d   = '0;
          end else if (rx_byte_i != HdrFirst) begin
            phase_d = PhHunt;
          end
        end
        PhData: begin
          sum_d = sum_q + rx_byte_i;
          idx_d = idx_q + 1'b1;
          if (idx_q == IdxW'(PayloadLen - 1)) phase_d = PhCheck;
        end
        PhCheck: begin
          if (rx_byte_i == ~sum_q) begin
            good  = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
          phase_d = PhHunt;
          idx_d   = '0;
          sum_d   = '0;
        end
        default: phase_d = PhHunt;
      endcase
      // Drop any partial frame at the end of a chunk.
      if (chunk_end_i) begin
        phase_d = PhHunt;
        idx_d   = '0;
        sum_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      idx_q   <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && phase_q == PhData) begin
      store_q[idx_q] <= rx_byte_i;
    end
  end

  always_comb begin
    for (int i = 0; i < PayloadLen; i++) begin
      frame_o.payload[i] = store_q[i];
    end
    frame_o.count = cnt_d;
  end

  assign push_o = good;

  `include "imu_frame_sync_checksum_parser_unit_assert.svh"

  `IFSC_ASSERT(a_idx_full_at_check, (phase_q == PhCheck) |-> (idx_q == IdxW'(PayloadLen)), "checksum phase without full payload")
  `IFSC_ASSERT(a_idx_bound, idx_q <= IdxW'(PayloadLen), "payload index out of range")
  `IFSC_ASSERT(a_hunt_clear, (phase_q == PhHunt || phase_q == PhHdr1) |-> (idx_q == '0 && sum_q == '0), "stale index or sum while hunting")
  `IFSC_ASSERT(a_count_step, push_o |=> (cnt_q == $past(cnt_q) + 1'b1), "frame count did not advance")

endmodule

>>> rtl/core/ifsc_fifo.sv
module ifsc_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  ifsc_pkg::ifsc_frame_t         wdata_i,
  input  logic                          pop_i,
  output ifsc_pkg::ifsc_frame_t         rdata_o,
  output ifsc_pkg::ifsc_fifo_status_t   status_o
);
  import ifsc_pkg::*;

  ifsc_frame_t         mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;

  function automatic logic [FifoPtrW-1:0] ptr_next(input logic [FifoPtrW-1:0] p);
    ptr_next = (p == FifoPtrW'(FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status_o.full  = (cnt_q == FifoCntW'(FifoDepth));
  assign status_o.empty = (cnt_q == '0);
  assign rdata_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  `include "imu_frame_sync_checksum_parser_unit_assert.svh"

  `IFSC_ASSERT(a_no_overflow, push_i |-> !status_o.full, "push into full queue")
  `IFSC_ASSERT(a_no_underflow, pop_i |-> !status_o.empty, "pop from empty queue")
  `IFSC_ASSERT(a_cnt_bound, cnt_q <= FifoCntW'(FifoDepth), "queue count out of range")
  `IFSC_ASSERT(a_cnt_ptr, (cnt_q == '0 || cnt_q == FifoCntW'(FifoDepth)) |-> (wr_ptr_q == rd_ptr_q), "queue pointers disagree with count")

endmodule

>>> rtl/core/ifsc_back.sv
module ifsc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ifsc_pkg::ifsc_fifo_status_t fifo_status_i,
  input  ifsc_pkg::ifsc_frame_t       frame_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ifsc_pkg::OutDataW-1:0] out_data_o
);
  import ifsc_pkg::*;

  logic signed [15:0]    raw  [ValueCount];
  logic signed [ProdW-1:0] prod [ValueCount];
  logic                  valid_q;
  logic [OutDataW-1:0]   data_q, data_d;
  logic                  load;

  // Scale each little-endian value by its full-scale factor (Q.15 result).
  always_comb begin
    for (int k = 0; k < ValueCount; k++) begin
      raw[k]  = {frame_i.payload[2*k+1], frame_i.payload[2*k]};
      prod[k] = raw[k] * ScaleTab[k];
    end
  end

  assign data_d = {5'b0, frame_i.count,
                   prod[9][23:0], prod[8][24:0], prod[7][24:0], prod[6][24:0],
                   prod[5][26:0], prod[4][26:0], prod[3][26:0],
                   prod[2][20:0], prod[1][20:0], prod[0][20:0]};

  assign load  = !fifo_status_i.empty && (!valid_q || out_ready_i);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> rtl/core/imu_frame_sync_checksum_parser_unit.sv
// Frame parser for a serial inertial sensor link.
// Input channel (s_axis): one received byte per item in tdata, tlast set on
// the last byte of a received chunk. The parser hunts for the header bytes
// 0x7F, 0x80 at any byte position, collects 20 payload bytes and checks the
// next byte against the inverted 8-bit payload sum.
// Output channel (m_axis): one item per good frame with ten scaled values
// and the running good-frame count. Bad frames and chunk ends emit nothing.
// Throughput: one byte per cycle; the front end takes a byte every cycle
// while the two-entry frame queue has room.
// Path: the queue is written at the edge that accepts the checksum byte;
// the scaling multipliers then load the output register from the queue
// head, which drives the result item.
// Reset: the parser returns to header hunt, the frame count clears and the
// queue and output register empty.
// Stall: while m_axis_tready_i is low the output item holds; up to two more
// good frames wait in the queue, and only with the queue full does
// s_axis_tready_o drop.
module imu_frame_sync_checksum_parser_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [7:0] rx_byte
  input  logic                          s_axis_tlast_i,  // chunk_end
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [20:0] accel_x, [41:21] accel_y, [62:42] accel_z, [89:63] rate_x,
  // [116:90] rate_y, [143:117] rate_z, [168:144] roll_angle,
  // [193:169] pitch_angle, [218:194] heading_angle,
  // [242:219] sensor_temperature, [258:243] frame_count, [263:259] zero
  output logic [ifsc_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import ifsc_pkg::*;

  ifsc_fifo_status_t fifo_status;
  ifsc_frame_t       push_frame;
  ifsc_frame_t       head_frame;
  logic              push;
  logic              pop;

  ifsc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .rx_byte_i     (s_axis_tdata_i),
    .chunk_end_i   (s_axis_tlast_i),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .frame_o       (push_frame)
  );

  ifsc_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_frame),
    .pop_i    (pop),
    .rdata_o  (head_frame),
    .status_o (fifo_status)
  );

  ifsc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_status),
    .frame_i       (head_frame),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_data_o    (m_axis_tdata_o)
  );

endmodule
